/* design/assert_macros.svh */
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, quiet while rst_n is low
`define CRM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same-cycle implication on top of the plain check
`define CRM_ASSERT_IMPL(label, pre, post, msg) \
    `CRM_ASSERT(label, (pre) |-> (post), msg)

`endif

/* design/crm_pkg.sv */
// constants and field layout for the chunk received map
`timescale 1ns / 1ps

package crm_pkg;

    // command codes carried on s_axis_tuser
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_ADD     = 2'd1;
    localparam logic [1:0] CMD_REQUEST = 2'd2;

    localparam int CMD_W     = 2;
    localparam int CHUNK_W   = 16;
    localparam int COUNT_W   = 11;
    localparam int ENTRY_W   = 10;
    localparam int BYTES_W   = 7;

    // output tdata layout
    localparam int ENTRY_LSB   = 0;
    localparam int BYTES_LSB   = ENTRY_LSB + ENTRY_W;
    localparam int PRESENT_BIT = BYTES_LSB + BYTES_W;
    localparam int OUT_DATA_W  = 24;

endpackage

/* design/chunk_received_map_with_missing_list.sv */
// chunk received map with first-missing pointer and missing-list generator
`timescale 1ns / 1ps

// Keeps one bit per chunk of a transfer in a byte-wide map memory plus a
// first-missing pointer. Commands arrive on s_axis_tuser: clear empties the
// map, add marks chunk s_axis_tdata and returns one transaction whose
// was_present bit tells whether it was already marked (or out of range),
// request returns the missing list in ascending order, a lone missing chunk
// as one entry and a run as two entries, high then low, at most MAX_ENTRIES
// entries, with tlast and the list length in bytes on the final one.
// Timing: one item at a time, s_axis_tready is high only while idle. Clear
// sweeps the ceil(min(MAX_CHUNKS,2047)/8) map bytes one byte per cycle (128
// bytes at the defaults); the same sweep runs once after reset before the
// first item is taken. Add reads the map byte, then writes it back and sends
// its reply once the result register is free. Request is served by the single
// bit-scan unit, which fetches a map byte and then examines one map bit per
// cycle; each entry waits until the pending one can move on to the result
// register. The chunk_count register may be written at any time on the cfg
// channel and is used as min(chunk_count, MAX_CHUNKS).
module chunk_received_map_with_missing_list
    import crm_pkg::*;
#(
    parameter int MAX_CHUNKS  = 1024,
    parameter int MAX_ENTRIES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // chunk_count write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data,        // chunk_count
    // command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHUNK_W-1:0]    s_axis_tdata,    // chunk_number
    input  logic [CMD_W-1:0]      s_axis_tuser,    // command
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,    // entry, list_bytes, was_present, zero pad
    output logic                  m_axis_tlast,    // last
    output logic                  m_axis_tuser     // no_entry
);

    // usable chunk range is bounded by the count register width
    localparam int LIMIT_I    = (MAX_CHUNKS > 2047) ? 2047 : MAX_CHUNKS;
    localparam int USED_BYTES = (LIMIT_I + 7) / 8;
    localparam int ADDR_W     = (USED_BYTES > 1) ? $clog2(USED_BYTES) : 1;
    localparam int CL_W       = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W      = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(LIMIT_I);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CLEAR   = 9'b000000010,
        S_ADD_RD  = 9'b000000100,
        S_ADD_WR  = 9'b000001000,
        S_SRD     = 9'b000010000,
        S_SBIT    = 9'b000100000,
        S_DECIDE  = 9'b001000000,
        S_EMIT_HI = 9'b010000000,
        S_EMIT_LO = 9'b100000000
    } state_t;

    // search phase; the final flush of the list is the separate flush_reg flag
    typedef enum logic [2:0] {
        PH_FIRST = 3'b001,
        PH_RUN   = 3'b010,
        PH_NEXT  = 3'b100
    } phase_t;

    state_t               state_reg, state_next;
    logic                 flush_reg, flush_next;
    phase_t               phase_reg, phase_next;
    logic                 target_reg, target_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [COUNT_W-1:0]   cn_reg, cn_next;
    logic [COUNT_W-1:0]   fm_reg, fm_next;
    logic [CL_W-1:0]      cl_reg, cl_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   add_num_reg, add_num_next;
    logic                 add_oor_reg, add_oor_next;
    logic [ENTRY_W-1:0]   pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;

    // output payload
    logic [ENTRY_W-1:0]   out_entry_reg, out_entry_next;
    logic                 out_last_reg, out_last_next;
    logic [BYTES_W-1:0]   out_bytes_reg, out_bytes_next;
    logic                 out_present_reg, out_present_next;
    logic                 out_none_reg, out_none_next;
    logic                 load_out;

    // map memory
    logic [7:0]           map_mem [USED_BYTES];
    logic [7:0]           rd_data_reg;
    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [7:0]           mem_wdata;

    logic [COUNT_W-1:0]   eff_count;
    logic                 in_fire, out_free, push_ok, at_end, search_done, cur_bit;
    logic                 add_present;
    logic [7:0]           bytes_wide;
    logic [POS_W-1:0]     pos_inc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE) && !flush_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign push_ok       = !pend_valid_reg || out_free;

    assign eff_count   = (count_reg > LIMIT) ? LIMIT : count_reg;
    assign at_end      = pos_reg >= {1'b0, eff_count};
    assign cur_bit     = rd_data_reg[pos_reg[2:0]];
    assign pos_inc     = pos_reg + POS_W'(1);
    assign add_present = add_oor_reg || rd_data_reg[add_num_reg[2:0]];
    assign bytes_wide  = 8'(cl_reg) << 1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_none_reg;
    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[ENTRY_LSB +: ENTRY_W] = out_entry_reg;
        m_axis_tdata[BYTES_LSB +: BYTES_W] = out_bytes_reg;
        m_axis_tdata[PRESENT_BIT]          = out_present_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        flush_next       = flush_reg;
        phase_next       = phase_reg;
        target_next      = target_reg;
        pos_next         = pos_reg;
        cn_next          = cn_reg;
        fm_next          = fm_reg;
        cl_next          = cl_reg;
        clr_addr_next    = clr_addr_reg;
        count_next       = count_reg;
        add_num_next     = add_num_reg;
        add_oor_next     = add_oor_reg;
        pend_next        = pend_reg;
        pend_valid_next  = pend_valid_reg;
        out_valid_next   = out_valid_reg;
        out_entry_next   = out_entry_reg;
        out_last_next    = out_last_reg;
        out_bytes_next   = out_bytes_reg;
        out_present_next = out_present_reg;
        out_none_next    = out_none_reg;
        load_out         = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = clr_addr_reg;
        mem_raddr        = pos_reg[ADDR_W+2:3];
        mem_wdata        = 8'h00;
        search_done      = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (flush_reg)
        begin
            // close the list: last pending entry or a no-entry transaction
            if (out_free)
            begin
                load_out         = 1'b1;
                out_entry_next   = pend_valid_reg ? pend_reg : '0;
                out_last_next    = 1'b1;
                out_bytes_next   = pend_valid_reg ? bytes_wide[BYTES_W-1:0] : '0;
                out_present_next = 1'b0;
                out_none_next    = !pend_valid_reg;
                pend_valid_next  = 1'b0;
                flush_next       = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (s_axis_tuser)
                            CMD_CLEAR:
                            begin
                                fm_next       = '0;
                                clr_addr_next = '0;
                                state_next    = S_CLEAR;
                            end
                            CMD_ADD:
                            begin
                                add_num_next = s_axis_tdata[COUNT_W-1:0];
                                add_oor_next = s_axis_tdata >= {5'b0, eff_count};
                                state_next   = S_ADD_RD;
                            end
                            CMD_REQUEST:
                            begin
                                pos_next    = {1'b0, fm_reg};
                                target_next = 1'b0;
                                phase_next  = PH_FIRST;
                                cl_next     = '0;
                                state_next  = S_SRD;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    mem_we = 1'b1;
                    if (clr_addr_reg == ADDR_W'(USED_BYTES - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        clr_addr_next = clr_addr_reg + ADDR_W'(1);
                    end
                end
                S_ADD_RD:
                begin
                    mem_re     = !add_oor_reg;
                    mem_raddr  = add_num_reg[ADDR_W+2:3];
                    state_next = S_ADD_WR;
                end
                S_ADD_WR:
                begin
                    if (out_free)
                    begin
                        mem_we    = !add_present;
                        mem_waddr = add_num_reg[ADDR_W+2:3];
                        mem_wdata = rd_data_reg | (8'h01 << add_num_reg[2:0]);
                        load_out         = 1'b1;
                        out_entry_next   = '0;
                        out_last_next    = 1'b1;
                        out_bytes_next   = '0;
                        out_present_next = add_present;
                        out_none_next    = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                S_SRD:
                begin
                    if (at_end)
                    begin
                        search_done = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_SBIT;
                    end
                end
                S_SBIT:
                begin
                    if (at_end || (cur_bit == target_reg))
                    begin
                        search_done = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        if (pos_reg[2:0] == 3'd7)
                        begin
                            state_next = S_SRD;
                        end
                    end
                end
                S_DECIDE:
                begin
                    // one slot left: the run or single goes out as its low number
                    if (cl_reg == CL_W'(MAX_ENTRIES - 1))
                    begin
                        state_next = S_EMIT_LO;
                    end
                    else
                    begin
                        pos_next    = pos_inc;
                        target_next = 1'b1;
                        phase_next  = PH_RUN;
                        state_next  = S_SRD;
                    end
                end
                S_EMIT_HI:
                begin
                    if (push_ok)
                    begin
                        pend_next  = ENTRY_W'(pos_reg - POS_W'(1));
                        cl_next    = cl_reg + CL_W'(1);
                        state_next = S_EMIT_LO;
                    end
                end
                S_EMIT_LO:
                begin
                    if (push_ok)
                    begin
                        pend_next = cn_reg[ENTRY_W-1:0];
                        cl_next   = cl_reg + CL_W'(1);
                        if (cl_reg >= CL_W'(MAX_ENTRIES - 1))
                        begin
                            flush_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            pos_next    = pos_inc;
                            target_next = 1'b0;
                            phase_next  = PH_NEXT;
                            state_next  = S_SRD;
                        end
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase

            // a new entry pushes the previous one out to the result register
            if ((state_reg == S_EMIT_HI || state_reg == S_EMIT_LO) && push_ok)
            begin
                pend_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    load_out         = 1'b1;
                    out_entry_next   = pend_reg;
                    out_last_next    = 1'b0;
                    out_bytes_next   = '0;
                    out_present_next = 1'b0;
                    out_none_next    = 1'b0;
                end
            end

            if (search_done)
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        fm_next = pos_reg[COUNT_W-1:0];
                        cn_next = pos_reg[COUNT_W-1:0];
                        if (at_end)
                        begin
                            flush_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DECIDE;
                        end
                    end
                    PH_RUN:
                    begin
                        // first present chunk right after a missing one: a single
                        if (pos_reg == ({1'b0, cn_reg} + POS_W'(1)))
                        begin
                            state_next = S_EMIT_LO;
                        end
                        else
                        begin
                            state_next = S_EMIT_HI;
                        end
                    end
                    PH_NEXT:
                    begin
                        cn_next = pos_reg[COUNT_W-1:0];
                        if (at_end)
                        begin
                            flush_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DECIDE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;   // map sweep after reset
            flush_reg      <= 1'b0;
            phase_reg      <= PH_FIRST;
            target_reg     <= 1'b0;
            pos_reg        <= '0;
            cn_reg         <= '0;
            fm_reg         <= '0;
            cl_reg         <= '0;
            clr_addr_reg   <= '0;
            count_reg      <= '0;
            add_oor_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flush_reg      <= flush_next;
            phase_reg      <= phase_next;
            target_reg     <= target_next;
            pos_reg        <= pos_next;
            cn_reg         <= cn_next;
            fm_reg         <= fm_next;
            cl_reg         <= cl_next;
            clr_addr_reg   <= clr_addr_next;
            count_reg      <= count_next;
            add_oor_reg    <= add_oor_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        add_num_reg     <= add_num_next;
        pend_reg        <= pend_next;
        out_entry_reg   <= out_entry_next;
        out_last_reg    <= out_last_next;
        out_bytes_reg   <= out_bytes_next;
        out_present_reg <= out_present_next;
        out_none_reg    <= out_none_next;
    end

    // map memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

endmodule

/* design/crm_checker.sv */
// port-level checker for the chunk received map, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crm_checker
    import crm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [CHUNK_W-1:0]    s_axis_tdata,
    input  logic [CMD_W-1:0]      s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic                  m_axis_tuser
);

    // a transaction without a list entry carries a zero entry
    `CRM_ASSERT_IMPL(a_none_zero_entry, m_axis_tvalid && m_axis_tuser, m_axis_tdata[ENTRY_LSB +: ENTRY_W] == '0, "no-entry transaction with nonzero entry")

    // length and presence flag only on the closing transaction
    `CRM_ASSERT_IMPL(a_mid_list_clean, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[BYTES_LSB +: BYTES_W] == '0 && !m_axis_tdata[PRESENT_BIT], "length or present bit before the last transaction")

    // an add reply is a single closing transaction without an entry
    `CRM_ASSERT_IMPL(a_present_is_add, m_axis_tvalid && m_axis_tdata[PRESENT_BIT], m_axis_tlast && m_axis_tuser, "present bit on a list entry")

    // no new command is taken while a list is still being delivered
    `CRM_ASSERT_IMPL(a_list_blocks_input, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "command accepted in the middle of a list")

    // a stalled result holds
    `CRM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

endmodule

bind chunk_received_map_with_missing_list crm_checker u_crm_checker (.*);
